### hdl/cckb_pkg.sv
// Shared types, constants and helper functions of the glyph blit unit.
`timescale 1ns / 1ps

package cckb_pkg;

  localparam int COORD_BITS  = 16;
  localparam int SCREEN_BITS = 16;
  localparam int POS_BITS    = (COORD_BITS > SCREEN_BITS ? COORD_BITS : SCREEN_BITS) + 1;
  localparam int LIN_BITS    = 2 * SCREEN_BITS;
  localparam int ADDR_BITS   = 34;
  localparam int COLOR_BITS  = 32;
  localparam int BPP_BITS    = 3;
  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = $clog2(QDEPTH);

  localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = 16'd1024;
  localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 16'd768;
  localparam logic [BPP_BITS-1:0]    BPP_RST           = 3'd4;
  localparam logic [COLOR_BITS-1:0]  KEY_RST           = 32'h0000_0000;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH    = 2'd0,
    CFG_SCREEN_HEIGHT   = 2'd1,
    CFG_PIX_BYTES       = 2'd2,
    CFG_TRANSPARENT_KEY = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [SCREEN_BITS-1:0] screen_width;
    logic [SCREEN_BITS-1:0] screen_height;
    logic [BPP_BITS-1:0]    pix_bytes;
    logic [COLOR_BITS-1:0]  transparent_key;
  } cfg_t;

  typedef struct packed {
    logic        start_glyph;
    logic        last_pixel;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
    logic [15:0] glyph_width;
    logic [31:0] draw_color;
    logic [31:0] pixel_value;
  } pixel_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0]  write_address;
    logic [COLOR_BITS-1:0] write_data;
  } fb_write_t;

  typedef struct packed {
    logic [SCREEN_BITS-1:0] x;
    logic [SCREEN_BITS-1:0] y;
    logic [COLOR_BITS-1:0]  color;
  } blit_req_t;

  function automatic logic [BPP_BITS-1:0] eff_bpp(input logic [BPP_BITS-1:0] bpp);
    logic [BPP_BITS-1:0] r;
    if (bpp == '0) begin
      r = BPP_BITS'(1);
    end else if (bpp > BPP_BITS'(4)) begin
      r = BPP_BITS'(4);
    end else begin
      r = bpp;
    end
    return r;
  endfunction

  function automatic logic [COLOR_BITS-1:0] byte_mask(input logic [BPP_BITS-1:0] bpp);
    logic [COLOR_BITS-1:0] m;
    unique case (bpp)
      BPP_BITS'(1): m = 32'h0000_00FF;
      BPP_BITS'(2): m = 32'h0000_FFFF;
      BPP_BITS'(3): m = 32'h00FF_FFFF;
      default:      m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

### hdl/clipped_color_key_glyph_blit_unit.sv
// Top level of the clipped color-key glyph blit unit.
// A drawn pixel's request passes the queue, stage s1 and the output register (dst_valid).
// Throughput: one pixel per clock; dst_stall holds the queue and the two-stage address path.
// The address path holds one 16x16 multiply-add in its first stage, then a pixel-size scale.
// Reset (rst, synchronous): registers 1024/768/4/0, glyph idle, queue and pipeline empty.
`timescale 1ns / 1ps

module clipped_color_key_glyph_blit_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                src_valid,
  output logic                src_stall,
  input  cckb_pkg::pixel_t    src_data,
  output logic                dst_valid,
  input  logic                dst_stall,
  output cckb_pkg::fb_write_t dst_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import cckb_pkg::*;

  cfg_t      cfg;
  logic      push, pop, empty, full;
  blit_req_t push_data, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width    <= SCREEN_WIDTH_RST;
      cfg.screen_height   <= SCREEN_HEIGHT_RST;
      cfg.pix_bytes       <= BPP_RST;
      cfg.transparent_key <= KEY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SCREEN_WIDTH:    cfg.screen_width    <= cfg_data[SCREEN_BITS-1:0];
        CFG_SCREEN_HEIGHT:   cfg.screen_height   <= cfg_data[SCREEN_BITS-1:0];
        CFG_PIX_BYTES:       cfg.pix_bytes       <= cfg_data[BPP_BITS-1:0];
        CFG_TRANSPARENT_KEY: cfg.transparent_key <= cfg_data[COLOR_BITS-1:0];
        default:             cfg <= cfg;
      endcase
    end
  end

  cckb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_data  (src_data),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  cckb_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  cckb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst_data  (dst_data)
  );

endmodule

### hdl/cckb_front.sv
// Front end: glyph counters, clipping and color-key test, request issue.
`timescale 1ns / 1ps

module cckb_front (
  input  logic               clk,
  input  logic               rst,
  input  cckb_pkg::cfg_t     cfg,
  input  logic               src_valid,
  output logic               src_stall,
  input  cckb_pkg::pixel_t   src_data,
  output logic               push,
  output cckb_pkg::blit_req_t push_data,
  input  logic               full
);
  import cckb_pkg::*;

  logic [COORD_BITS-1:0] column_count;
  logic [COORD_BITS-1:0] row_count;
  logic [COORD_BITS-1:0] latched_origin_x;
  logic [COORD_BITS-1:0] latched_origin_y;
  logic [COORD_BITS-1:0] latched_width;
  logic [COLOR_BITS-1:0] latched_color;
  logic                  glyph_active;

  logic                  accept;
  logic                  active;
  logic [COORD_BITS-1:0] ox, oy, w, col, row, next_col;
  logic [COLOR_BITS-1:0] color, mask;
  logic [POS_BITS-1:0]   sx, sy;
  logic                  wrap;
  logic                  hit;

  assign src_stall = full;
  assign accept    = src_valid && !full;

  always_comb begin
    active   = src_data.start_glyph || glyph_active;
    ox       = src_data.start_glyph ? src_data.origin_x[COORD_BITS-1:0] : latched_origin_x;
    oy       = src_data.start_glyph ? src_data.origin_y[COORD_BITS-1:0] : latched_origin_y;
    w        = src_data.start_glyph ? src_data.glyph_width[COORD_BITS-1:0] : latched_width;
    color    = src_data.start_glyph ? src_data.draw_color : latched_color;
    col      = src_data.start_glyph ? '0 : column_count;
    row      = src_data.start_glyph ? '0 : row_count;
    sx       = POS_BITS'(ox) + POS_BITS'(col);
    sy       = POS_BITS'(oy) + POS_BITS'(row);
    mask     = byte_mask(eff_bpp(cfg.pix_bytes));
    hit      = active && (sx < POS_BITS'(cfg.screen_width)) &&
               (sy < POS_BITS'(cfg.screen_height)) &&
               (((src_data.pixel_value ^ cfg.transparent_key) & mask) != '0);
    next_col = col + COORD_BITS'(1);
    wrap     = (next_col == w);
    push            = accept && hit;
    push_data.x     = sx[SCREEN_BITS-1:0];
    push_data.y     = sy[SCREEN_BITS-1:0];
    push_data.color = color & mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count     <= '0;
      row_count        <= '0;
      latched_origin_x <= '0;
      latched_origin_y <= '0;
      latched_width    <= COORD_BITS'(1);
      latched_color    <= '0;
      glyph_active     <= 1'b0;
    end else if (accept && active) begin
      latched_origin_x <= ox;
      latched_origin_y <= oy;
      latched_width    <= w;
      latched_color    <= color;
      column_count     <= wrap ? '0 : next_col;
      row_count        <= wrap ? row + COORD_BITS'(1) : row;
      glyph_active     <= !src_data.last_pixel;
    end
  end

endmodule

### hdl/cckb_fifo.sv
// Short request queue between the front end and the address pipeline.
`timescale 1ns / 1ps

module cckb_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cckb_pkg::blit_req_t push_data,
  input  logic                pop,
  output cckb_pkg::blit_req_t head,
  output logic                empty,
  output logic                full
);
  import cckb_pkg::*;

  blit_req_t            mem [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_BITS+1)'(QDEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (QPTR_BITS+1)'(1);
        2'b01:   count <= count - (QPTR_BITS+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/cckb_back.sv
// Back end: linear position multiply, byte scaling and output register.
`timescale 1ns / 1ps

module cckb_back (
  input  logic                clk,
  input  logic                rst,
  input  cckb_pkg::cfg_t      cfg,
  output logic                pop,
  input  cckb_pkg::blit_req_t head,
  input  logic                empty,
  output logic                dst_valid,
  input  logic                dst_stall,
  output cckb_pkg::fb_write_t dst_data
);
  import cckb_pkg::*;

  logic                  en;
  logic                  s1_valid;
  logic [LIN_BITS-1:0]   s1_pos;
  logic [COLOR_BITS-1:0] s1_color;
  logic [ADDR_BITS-1:0]  pos_ext;
  logic [ADDR_BITS-1:0]  addr_next;

  assign en  = !dst_valid || !dst_stall;
  assign pop = en && !empty;

  always_comb begin
    pos_ext = ADDR_BITS'(s1_pos);
    unique case (eff_bpp(cfg.pix_bytes))
      BPP_BITS'(1): addr_next = pos_ext;
      BPP_BITS'(2): addr_next = pos_ext << 1;
      BPP_BITS'(3): addr_next = pos_ext + (pos_ext << 1);
      default:      addr_next = pos_ext << 2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      dst_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= !empty;
      dst_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pos   <= LIN_BITS'(head.y) * LIN_BITS'(cfg.screen_width) + LIN_BITS'(head.x);
      s1_color <= head.color;
      dst_data.write_address <= addr_next;
      dst_data.write_data    <= s1_color;
    end
  end

endmodule

### hdl/cckb_checker.sv
// Port-level checker for the glyph blit unit and its bind.
`timescale 1ns / 1ps

module cckb_checker (
  input logic                clk,
  input logic                rst,
  input logic                src_valid,
  input logic                src_stall,
  input logic                dst_valid,
  input logic                dst_stall,
  input cckb_pkg::fb_write_t dst_data
);

  logic accept;
  assign accept = src_valid && !src_stall;

  a_reset_empty: assert property (@(posedge clk) rst |=> !dst_valid)
    else $error("write request valid right after reset");

  a_no_phantom: assert property (@(posedge clk)
    rst ##1 !accept ##1 !accept |=> !dst_valid)
    else $error("write request with no pixel accepted since reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_data))
    else $error("stalled write request dropped or changed");

endmodule

bind clipped_color_key_glyph_blit_unit cckb_checker u_cckb_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_stall (src_stall),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_data  (dst_data)
);
